// ===== rtl/per_key_interval_merge_index_unit_macros.svh =====
// Assertion macros for the per-key interval merge index unit.
`ifndef PER_KEY_INTERVAL_MERGE_INDEX_UNIT_MACROS_SVH
`define PER_KEY_INTERVAL_MERGE_INDEX_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PKIMI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PKIMI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PKIMI_ASSERT(lbl, prop)
`define PKIMI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/pkimi_pkg.sv =====
// Shared types and constants of the per-key interval merge index unit.
`default_nettype none
package pkimi_pkg;
  localparam int KEY_COUNT = 128;
  localparam logic [6:0] KEY_LAST = 7'd127;
  localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_FIN   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic lt_b;
    logic eq_b;
    logic lt_f;
  } cmp_res_t;
endpackage
`default_nettype wire

// ===== rtl/pkimi_ram.sv =====
// Simple dual-port RAM with registered read data.
`default_nettype none
module pkimi_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/pkimi_cmp.sv =====
// Shared signed 64-bit comparator for begin and finish pairs.
`default_nettype none
module pkimi_cmp (
  input  wire logic signed [63:0] a_b,
  input  wire logic signed [63:0] a_f,
  input  wire logic signed [63:0] b_b,
  input  wire logic signed [63:0] b_f,
  output pkimi_pkg::cmp_res_t     res
);
  import pkimi_pkg::*;

  assign res.lt_b = a_b < b_b;
  assign res.eq_b = a_b == b_b;
  assign res.lt_f = a_f < b_f;
endmodule
`default_nettype wire

// ===== rtl/per_key_interval_merge_index_unit.sv =====
// Top level: sequencer over the interval RAM, fill RAM and shared comparator.
// One transaction at a time.
// Query: per key, a binary search over the key's entries, one interval RAM read per search step.
// Finalize: per key with n entries, n - 1 bubble passes and one merge pass through the
// single-read-port interval RAM; keys with n below 2 are skipped.
// Reset clears the state machine, the result valid flag and all fill valid bits.
`default_nettype none
`include "per_key_interval_merge_index_unit_macros.svh"
module per_key_interval_merge_index_unit #(
  parameter int INTERVALS_PER_KEY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation[1:0]
  input  wire logic [1:0]   in_tuser,
  // note_key[15:0], note_start[79:16], note_duration[143:80], open_ended[144],
  // query_time[208:145], zero pad
  input  wire logic [215:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], active_low[65:2], active_high[129:66], zero pad
  output logic [135:0]      out_tdata
);
  import pkimi_pkg::*;

  localparam int N = INTERVALS_PER_KEY;
  localparam int DEPTH = KEY_COUNT * N;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(N + 1);
  localparam int EW = 129;

  localparam logic [4:0] S_IDLE = 5'd0, S_ADD_CHK = 5'd1, S_ADD_FILL = 5'd2,
    S_FIN_KEY = 5'd3, S_FIN_N = 5'd4, S_BS_RD0 = 5'd5, S_BS_LD0 = 5'd6,
    S_BS_CMP = 5'd7, S_BS_END = 5'd8, S_MG_RD0 = 5'd9, S_MG_LD0 = 5'd10,
    S_MG_CMP = 5'd11, S_MG_END = 5'd12, S_Q_KEY = 5'd13, S_Q_N = 5'd14,
    S_Q_STEP = 5'd15, S_Q_CMP = 5'd16, S_Q_TEST = 5'd17, S_DONE = 5'd18;

  function automatic logic [AW-1:0] ent_addr(input logic [6:0] k, input logic [FW-1:0] i);
    ent_addr = AW'(k) * AW'(N) + AW'(i);
  endfunction

  logic [4:0] state_r, state_nxt;
  logic [1:0] op_r;
  logic signed [15:0] key_r;
  logic signed [63:0] start_r, dur_r, qt_r;
  logic open_r;
  logic [6:0] k_r, k_nxt;
  logic [FW-1:0] n_r, n_nxt, pass_r, pass_nxt, j_r, j_nxt, m_r, m_nxt;
  logic [FW-1:0] lo_r, lo_nxt, cnt_r, cnt_nxt, mid_r, mid_nxt;
  logic signed [63:0] cur_b_r, cur_b_nxt, cur_f_r, cur_f_nxt;
  logic cur_u_r, cur_u_nxt;
  logic [127:0] mask_r, mask_nxt;
  logic [1:0] status_r, status_nxt;
  logic out_valid_r;
  logic [1:0] out_status_r;
  logic [127:0] out_mask_r;
  logic [KEY_COUNT-1:0] fvld_r;
  logic fvld_rd_r;

  logic in_acc, out_load, clr;
  logic ent_we, fill_we;
  logic [AW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic [6:0] fill_addr, fill_raddr;
  logic [FW-1:0] fill_wdata, fill_rdata, fill_cur;
  logic signed [63:0] rd_b, rd_f;
  logic rd_u;
  logic signed [63:0] ca_b, ca_f, cb_b, cb_f;
  cmp_res_t cmp;
  logic [64:0] sum;
  logic ovf, add_bad, gt;
  logic signed [63:0] fin_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_mask_r, out_status_r};

  assign rd_b = ent_rdata[128:65];
  assign rd_f = ent_rdata[64:1];
  assign rd_u = ent_rdata[0];
  assign fill_cur = fvld_rd_r ? fill_rdata : '0;
  assign fill_raddr = (state_r == S_ADD_CHK) ? key_r[6:0] : k_r;
  assign fill_addr = (state_r == S_ADD_FILL) ? key_r[6:0] : k_r;

  assign sum = {start_r[63], start_r} + {dur_r[63], dur_r};
  assign ovf = !sum[64] && sum[63];
  assign fin_val = (open_r || ovf) ? TS_MAX : sum[63:0];
  assign add_bad = (key_r[15:7] != 9'd0) || dur_r[63] || (dur_r == 64'sd0) ||
                   (!open_r && (start_r == TS_MAX));
  assign gt = cmp.lt_b || (cmp.eq_b && cmp.lt_f);

  always_comb begin
    ca_b = qt_r;
    ca_f = qt_r;
    cb_b = rd_b;
    cb_f = rd_f;
    case (state_r)
      S_BS_CMP: begin
        ca_b = rd_b;
        ca_f = rd_f;
        cb_b = cur_b_r;
        cb_f = cur_f_r;
      end
      S_MG_CMP: begin
        ca_b = cur_f_r;
        ca_f = cur_f_r;
      end
      default: begin
        ca_b = qt_r;
      end
    endcase
  end

  pkimi_cmp u_cmp (.a_b(ca_b), .a_f(ca_f), .b_b(cb_b), .b_f(cb_f), .res(cmp));

  pkimi_ram #(.W(EW), .DEPTH(DEPTH), .AW(AW)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  pkimi_ram #(.W(FW), .DEPTH(KEY_COUNT), .AW(7)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_addr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    n_nxt = n_r;
    pass_nxt = pass_r;
    j_nxt = j_r;
    m_nxt = m_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    mid_nxt = mid_r;
    cur_b_nxt = cur_b_r;
    cur_f_nxt = cur_f_r;
    cur_u_nxt = cur_u_r;
    mask_nxt = mask_r;
    status_nxt = status_r;
    ent_we = 1'b0;
    ent_waddr = '0;
    ent_wdata = '0;
    ent_raddr = '0;
    fill_we = 1'b0;
    fill_wdata = '0;
    clr = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          k_nxt = '0;
          mask_nxt = '0;
          status_nxt = ST_OK;
          case (in_tuser)
            OP_CLEAR: begin
              clr = 1'b1;
              state_nxt = S_DONE;
            end
            OP_ADD: state_nxt = S_ADD_CHK;
            OP_FIN: state_nxt = S_FIN_KEY;
            default: state_nxt = S_Q_KEY;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (add_bad) begin
          status_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADD_FILL;
        end
      end
      S_ADD_FILL: begin
        if (fill_cur >= FW'(N)) begin
          status_nxt = ST_FULL;
        end else begin
          ent_we = 1'b1;
          ent_waddr = ent_addr(key_r[6:0], fill_cur);
          ent_wdata = {start_r, fin_val, open_r};
          fill_we = 1'b1;
          fill_wdata = fill_cur + FW'(1);
        end
        state_nxt = S_DONE;
      end
      S_FIN_KEY: state_nxt = S_FIN_N;
      S_FIN_N: begin
        n_nxt = fill_cur;
        pass_nxt = '0;
        if (fill_cur <= FW'(1)) begin
          if (k_r == KEY_LAST) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 7'd1;
            state_nxt = S_FIN_KEY;
          end
        end else begin
          state_nxt = S_BS_RD0;
        end
      end
      S_BS_RD0: begin
        ent_raddr = ent_addr(k_r, '0);
        state_nxt = S_BS_LD0;
      end
      S_BS_LD0: begin
        cur_b_nxt = rd_b;
        cur_f_nxt = rd_f;
        cur_u_nxt = rd_u;
        j_nxt = FW'(1);
        ent_raddr = ent_addr(k_r, FW'(1));
        state_nxt = S_BS_CMP;
      end
      S_BS_CMP: begin
        ent_we = 1'b1;
        ent_waddr = ent_addr(k_r, j_r - FW'(1));
        if (gt) begin
          ent_wdata = ent_rdata;
        end else begin
          ent_wdata = {cur_b_r, cur_f_r, cur_u_r};
          cur_b_nxt = rd_b;
          cur_f_nxt = rd_f;
          cur_u_nxt = rd_u;
        end
        if (j_r == n_r - FW'(1)) begin
          state_nxt = S_BS_END;
        end else begin
          j_nxt = j_r + FW'(1);
          ent_raddr = ent_addr(k_r, j_r + FW'(1));
        end
      end
      S_BS_END: begin
        ent_we = 1'b1;
        ent_waddr = ent_addr(k_r, n_r - FW'(1));
        ent_wdata = {cur_b_r, cur_f_r, cur_u_r};
        if (pass_r == n_r - FW'(2)) begin
          state_nxt = S_MG_RD0;
        end else begin
          pass_nxt = pass_r + FW'(1);
          state_nxt = S_BS_RD0;
        end
      end
      S_MG_RD0: begin
        ent_raddr = ent_addr(k_r, '0);
        state_nxt = S_MG_LD0;
      end
      S_MG_LD0: begin
        cur_b_nxt = rd_b;
        cur_f_nxt = rd_f;
        cur_u_nxt = rd_u;
        m_nxt = FW'(1);
        j_nxt = FW'(1);
        ent_raddr = ent_addr(k_r, FW'(1));
        state_nxt = S_MG_CMP;
      end
      S_MG_CMP: begin
        if (cur_u_r || !cmp.lt_b) begin
          if (cmp.lt_f) begin
            cur_f_nxt = rd_f;
          end
          cur_u_nxt = cur_u_r || rd_u;
        end else begin
          ent_we = 1'b1;
          ent_waddr = ent_addr(k_r, m_r - FW'(1));
          ent_wdata = {cur_b_r, cur_f_r, cur_u_r};
          cur_b_nxt = rd_b;
          cur_f_nxt = rd_f;
          cur_u_nxt = rd_u;
          m_nxt = m_r + FW'(1);
        end
        if (j_r == n_r - FW'(1)) begin
          state_nxt = S_MG_END;
        end else begin
          j_nxt = j_r + FW'(1);
          ent_raddr = ent_addr(k_r, j_r + FW'(1));
        end
      end
      S_MG_END: begin
        ent_we = 1'b1;
        ent_waddr = ent_addr(k_r, m_r - FW'(1));
        ent_wdata = {cur_b_r, cur_f_r, cur_u_r};
        fill_we = 1'b1;
        fill_wdata = m_r;
        if (k_r == KEY_LAST) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 7'd1;
          state_nxt = S_FIN_KEY;
        end
      end
      S_Q_KEY: state_nxt = S_Q_N;
      S_Q_N: begin
        lo_nxt = '0;
        cnt_nxt = fill_cur;
        state_nxt = S_Q_STEP;
      end
      S_Q_STEP: begin
        if (cnt_r == '0) begin
          if (lo_r == '0) begin
            if (k_r == KEY_LAST) begin
              state_nxt = S_DONE;
            end else begin
              k_nxt = k_r + 7'd1;
              state_nxt = S_Q_KEY;
            end
          end else begin
            ent_raddr = ent_addr(k_r, lo_r - FW'(1));
            state_nxt = S_Q_TEST;
          end
        end else begin
          mid_nxt = lo_r + (cnt_r >> 1);
          ent_raddr = ent_addr(k_r, lo_r + (cnt_r >> 1));
          state_nxt = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        if (cmp.lt_b) begin
          cnt_nxt = cnt_r >> 1;
        end else begin
          lo_nxt = mid_r + FW'(1);
          cnt_nxt = cnt_r - (cnt_r >> 1) - FW'(1);
        end
        state_nxt = S_Q_STEP;
      end
      S_Q_TEST: begin
        mask_nxt[k_r] = rd_u || cmp.lt_f;
        if (k_r == KEY_LAST) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 7'd1;
          state_nxt = S_Q_KEY;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fvld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clr) begin
        fvld_r <= '0;
      end else if (fill_we) begin
        fvld_r[fill_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_tuser;
      key_r <= in_tdata[15:0];
      start_r <= in_tdata[79:16];
      dur_r <= in_tdata[143:80];
      open_r <= in_tdata[144];
      qt_r <= in_tdata[208:145];
    end
    fvld_rd_r <= fvld_r[fill_raddr];
    k_r <= k_nxt;
    n_r <= n_nxt;
    pass_r <= pass_nxt;
    j_r <= j_nxt;
    m_r <= m_nxt;
    lo_r <= lo_nxt;
    cnt_r <= cnt_nxt;
    mid_r <= mid_nxt;
    cur_b_r <= cur_b_nxt;
    cur_f_r <= cur_f_nxt;
    cur_u_r <= cur_u_nxt;
    mask_r <= mask_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_mask_r <= (op_r == OP_QUERY) ? mask_r : '0;
    end
  end

  `PKIMI_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `PKIMI_ASSERT(a_fill_bound, fill_we |-> (fill_wdata <= FW'(N)))
  `PKIMI_ASSERT(a_mask_only_query, (out_valid_r && out_status_r != ST_OK) |-> (out_mask_r == '0))
  `PKIMI_ASSERT_ALWAYS(a_no_clear_busy, clr |-> (state_r == S_IDLE))
endmodule
`default_nettype wire
